/* hdl/srsm_pkg.sv */
// Package with shared constants, codes and the request descriptor of the reassembler.
package srsm_pkg;

   localparam int unsigned MAX_SDU_BYTES = 2048;
   localparam int unsigned ADDR_W = $clog2(MAX_SDU_BYTES);
   localparam int unsigned HDR_BYTES = 8;
   localparam logic [12:0] COUNT_SAT = 13'd8191;

   typedef enum logic [1:0] {
      REG_MAGIC = 2'd0,
      REG_START = 2'd1,
      REG_END   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_MID    = 3'd0,
      ST_TAKEN  = 3'd1,
      ST_DONE   = 3'd2,
      ST_REJECT = 3'd3,
      ST_READ   = 3'd4,
      ST_EMPTY  = 3'd5
   } status_type;

   // One classified request handed from the front end to the back end.
   typedef struct packed {
      logic              is_read;
      logic              idle;
      logic              first;
      logic              is_payload;
      logic              pos_ok;
      logic              start_match;
      logic [ADDR_W-1:0] pos;
      logic [15:0]       offset;
      logic [7:0]        data;
      logic              fin;
      logic              hdr_bad;
      logic              geom_bad;
      logic              start;
      logic              last;
      logic [15:0]       id;
      logic [15:0]       total;
      logic [11:0]       payload;
      logic [11:0]       seg_end;
   } op_type;

endpackage

/* hdl/srsm_ram.sv */
// Generic simple dual-port RAM (one write port, one read port) with registered read and read enable.
module srsm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

/* hdl/srsm_front.sv */
// Front end: tracks PDU bytes and header, classifies each request.
module srsm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic                kind,
   input  logic [7:0]          data_byte,
   input  logic                pdu_end,
   input  logic [7:0]          header_magic,
   input  logic [7:0]          start_flag_mask,
   input  logic [7:0]          end_flag_mask,
   output srsm_pkg::op_type    op
);
   import srsm_pkg::*;

   logic [12:0] cnt_ff, cnt_in;
   logic [63:0] hdr_ff, hdr_in;
   logic [63:0] hdr_base, hdr_new;
   logic [16:0] pos_full, payload_full, end_full;
   logic [15:0] cur_offset, total;
   logic [12:0] cnt_new;

   // Header shift and byte count of the PDU in progress.
   always_comb begin
      hdr_base = (cnt_ff == '0) ? '0 : hdr_ff;
      hdr_new = (cnt_ff < 13'(HDR_BYTES)) ? {hdr_base[55:0], data_byte} : hdr_base;
      cnt_new = (cnt_ff < COUNT_SAT) ? cnt_ff + 13'd1 : cnt_ff;
      cnt_in = cnt_ff;
      hdr_in = hdr_ff;
      if (fire && !kind) begin
         cnt_in = pdu_end ? '0 : cnt_new;
         hdr_in = pdu_end ? '0 : hdr_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         hdr_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         hdr_ff <= hdr_in;
      end
   end

   // Classification of the current request.
   always_comb begin
      cur_offset = hdr_ff[15:0];
      pos_full = {1'b0, cur_offset} + {4'd0, cnt_ff} - 17'(HDR_BYTES);
      total = hdr_new[31:16];
      payload_full = {4'd0, cnt_new} - 17'(HDR_BYTES);
      end_full = {1'b0, hdr_new[15:0]} + payload_full;
      op.is_read = kind;
      op.idle = (cnt_ff == '0);
      op.first = !kind && (cnt_ff == '0);
      op.is_payload = !kind && (cnt_ff >= 13'(HDR_BYTES)) && (cnt_ff < COUNT_SAT);
      op.pos_ok = pos_full < 17'(MAX_SDU_BYTES);
      op.start_match = (hdr_ff[63:56] == header_magic) && ((hdr_ff[55:48] & start_flag_mask) != '0);
      op.pos = pos_full[ADDR_W-1:0];
      op.offset = cur_offset;
      op.data = data_byte;
      op.fin = !kind && pdu_end;
      op.hdr_bad = (cnt_new < 13'(HDR_BYTES)) || (cnt_new >= COUNT_SAT)
                   || (hdr_new[63:56] != header_magic);
      op.geom_bad = (total == '0) || ({1'b0, total} > 17'(MAX_SDU_BYTES))
                    || (hdr_new[15:0] > total) || (payload_full > {1'b0, total})
                    || (end_full > {1'b0, total});
      op.start = (hdr_new[55:48] & start_flag_mask) != '0;
      op.last = (hdr_new[55:48] & end_flag_mask) != '0;
      op.id = hdr_new[47:32];
      op.total = total;
      op.payload = payload_full[11:0];
      op.seg_end = end_full[11:0];
   end
endmodule

/* hdl/srsm_fifo.sv */
// Two-entry queue of classified requests between front and back end.
module srsm_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  srsm_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output srsm_pkg::op_type head
);
   import srsm_pkg::*;

   op_type      entry_ff [2];
   logic        wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]  count_ff, count_in;

   // Pointer and fill-level update.
   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_op;
      end
   end

   assign full = (count_ff == 2'd2);
   assign valid = (count_ff != '0);
   assign head = entry_ff[rptr_ff];
endmodule

/* hdl/srsm_back.sv */
// Back end: context, store writes, PDU completion checks, reads and response register.
module srsm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   input  srsm_pkg::op_type op,
   output logic             op_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [11:0]      rsp_consumed_bytes,
   output logic [7:0]       rsp_sdu_byte,
   output logic             rsp_sdu_last
);
   import srsm_pkg::*;

   logic        active_ff, active_in;
   logic [15:0] id_ff, id_in, total_ff, total_in;
   logic [11:0] rc_ff, rc_in, rl_ff, rl_in, rp_ff, rp_in;
   logic        vld_ff, rdsel_ff, last_ff, last_in;
   status_type  st_ff, st_in;
   logic [11:0] cons_ff, cons_in;
   logic        advance, wr_en, rd_ok;
   logic [11:0] rc_eff;
   logic [7:0]  ram_q;

   assign advance = op_valid && (!vld_ff || rsp_ready);
   assign op_pop = advance;
   assign wr_en = advance && op.is_payload && op.pos_ok
                  && (op.start_match ? (op.offset == '0) : (op.offset == {4'd0, rc_ff}));
   assign rd_ok = op.is_read && op.idle && (rl_ff != '0) && (rp_ff < rl_ff);

   // Context update and result for the request at the head of the queue.
   always_comb begin
      active_in = active_ff;
      id_in = id_ff;
      total_in = total_ff;
      rc_in = rc_ff;
      rl_in = rl_ff;
      rp_in = rp_ff;
      st_in = ST_MID;
      cons_in = '0;
      last_in = 1'b0;
      rc_eff = rc_ff;
      if (op.is_read) begin
         if (rd_ok) begin
            st_in = ST_READ;
            last_in = (rp_ff + 12'd1 == rl_ff);
            rp_in = rp_ff + 12'd1;
            if (last_in) begin
               rl_in = '0;
               rp_in = '0;
            end
         end else begin
            st_in = ST_EMPTY;
         end
      end else begin
         if (op.first) begin
            rl_in = '0;
            rp_in = '0;
         end
         if (op.fin) begin
            st_in = ST_REJECT;
            if (op.hdr_bad) begin
               st_in = ST_REJECT;
            end else if (op.geom_bad) begin
               if (op.start) begin
                  active_in = 1'b0;
                  id_in = '0;
                  total_in = '0;
                  rc_in = '0;
               end
            end else if (!op.start && (!active_ff || id_ff != op.id || total_ff != op.total)) begin
               st_in = ST_REJECT;
            end else begin
               if (op.start) begin
                  active_in = 1'b1;
                  id_in = op.id;
                  total_in = op.total;
                  rc_eff = '0;
                  rc_in = '0;
               end
               if (op.offset > {4'd0, rc_eff}) begin
                  st_in = ST_REJECT;
               end else if (op.offset < {4'd0, rc_eff} && op.seg_end > rc_eff) begin
                  st_in = ST_REJECT;
               end else begin
                  if (op.offset == {4'd0, rc_eff}) begin
                     rc_in = op.seg_end;
                     cons_in = op.payload;
                  end
                  if (op.last) begin
                     if ({4'd0, op.seg_end} != op.total || {4'd0, rc_in} != op.total) begin
                        st_in = ST_REJECT;
                     end else begin
                        st_in = ST_DONE;
                        rl_in = op.total[11:0];
                        rp_in = '0;
                        active_in = 1'b0;
                        id_in = '0;
                        total_in = '0;
                        rc_in = '0;
                     end
                  end else begin
                     st_in = ST_TAKEN;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         id_ff <= '0;
         total_ff <= '0;
         rc_ff <= '0;
         rl_ff <= '0;
         rp_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         if (advance) begin
            active_ff <= active_in;
            id_ff <= id_in;
            total_ff <= total_in;
            rc_ff <= rc_in;
            rl_ff <= rl_in;
            rp_ff <= rp_in;
         end
         if (advance) begin
            vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   // Response register; the store's read data lines up with it.
   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff <= st_in;
         cons_ff <= cons_in;
         last_ff <= last_in;
         rdsel_ff <= op.is_read && rd_ok;
      end
   end

   srsm_ram #(.WIDTH(8), .DEPTH(MAX_SDU_BYTES)) u_store (
      .clock (clock),
      .we    (wr_en),
      .waddr (op.pos),
      .wdata (op.data),
      .re    (advance && rd_ok),
      .raddr (rp_ff[ADDR_W-1:0]),
      .rdata (ram_q)
   );

   assign rsp_valid = vld_ff;
   assign rsp_status = st_ff;
   assign rsp_consumed_bytes = cons_ff;
   assign rsp_sdu_byte = rdsel_ff ? ram_q : '0;
   assign rsp_sdu_last = last_ff;
endmodule

/* hdl/segment_reassembler.sv */
// A request passes through the queue entry and then the response register before its response is valid.
// Throughput: one request per cycle; the front end takes a request while the two-entry queue has room.
// A held response stops the back end; the queue then fills after at most two more requests and req_ready drops.
// A request needs at most one store access, a write for payload bytes or a read for drain requests.
// Reset clears the context and counters and restores the default configuration; the store keeps its contents.
// Store entries never written are never read, so the store needs no clearing pass.
module segment_reassembler (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        req_pdu_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_consumed_bytes,
   output logic [7:0]  rsp_sdu_byte,
   output logic        rsp_sdu_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import srsm_pkg::*;

   logic [7:0] magic_ff, smask_ff, emask_ff;
   logic       fire, q_full, q_valid, q_pop;
   op_type     front_op, q_head;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= 8'd165;
         smask_ff <= 8'd1;
         emask_ff <= 8'd2;
      end else if (csr_we) begin
         case (csr_index)
            REG_MAGIC: magic_ff <= csr_wdata;
            REG_START: smask_ff <= csr_wdata;
            REG_END:   emask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = !q_full;
   assign fire = req_valid && req_ready;

   srsm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .kind            (req_kind),
      .data_byte       (req_data_byte),
      .pdu_end         (req_pdu_end),
      .header_magic    (magic_ff),
      .start_flag_mask (smask_ff),
      .end_flag_mask   (emask_ff),
      .op              (front_op)
   );

   srsm_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (fire),
      .push_op (front_op),
      .full    (q_full),
      .pop     (q_pop),
      .valid   (q_valid),
      .head    (q_head)
   );

   srsm_back u_back (
      .clock              (clock),
      .reset              (reset),
      .op_valid           (q_valid),
      .op                 (q_head),
      .op_pop             (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_consumed_bytes (rsp_consumed_bytes),
      .rsp_sdu_byte       (rsp_sdu_byte),
      .rsp_sdu_last       (rsp_sdu_last)
   );

`ifndef SYNTHESIS
   a_last_is_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sdu_last |-> rsp_status == ST_READ)
      else $error("sdu_last without a read response");
   a_consumed_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_consumed_bytes != '0 |->
      (rsp_status == ST_TAKEN || rsp_status == ST_DONE || rsp_status == ST_REJECT))
      else $error("consumed bytes outside a PDU end");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");
   a_byte_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_READ |-> rsp_sdu_byte == '0)
      else $error("sdu byte on a non-read response");
`endif
endmodule

/* test/segment_reassembler_test.sv */
// Self-checking testbench for the segment reassembler, with a response scoreboard.
import srsm_pkg::*;

typedef struct {
   status_type  status;
   logic [11:0] consumed;
   logic [7:0]  sdu_byte;
   logic        sdu_last;
} rsp_item_type;

class reassembly_scoreboard;
   // Mirror of the reassembly state and the three registers.
   logic [7:0]   store [MAX_SDU_BYTES];
   bit           ctx_on;
   logic [15:0]  ctx_id;
   int unsigned  ctx_total;
   int unsigned  got_count;
   logic [63:0]  hdr;
   int unsigned  pdu_len;
   int unsigned  sdu_len;
   int unsigned  rd_ptr;
   logic [7:0]   magic;
   logic [7:0]   start_mask;
   logic [7:0]   end_mask;
   rsp_item_type pending_q [$];
   int unsigned  errors;
   int unsigned  requests;

   function new();
      magic = 8'd165;
      start_mask = 8'd1;
      end_mask = 8'd2;
      foreach (store[i]) store[i] = 8'd0;
      drop_context();
      hdr = '0;
      pdu_len = 0;
      sdu_len = 0;
      rd_ptr = 0;
      errors = 0;
      requests = 0;
   endfunction

   function void drop_context();
      ctx_on = 0;
      ctx_id = '0;
      ctx_total = 0;
      got_count = 0;
   endfunction

   function void set_reg(csr_index_type idx, logic [7:0] value);
      case (idx)
         REG_MAGIC: magic = value;
         REG_START: start_mask = value;
         REG_END: end_mask = value;
         default: ;
      endcase
   endfunction

   function int unsigned pending();
      return pending_q.size();
   endfunction

   // Verdict on a whole PDU at its last byte.
   function status_type close_pdu(int unsigned len, output int unsigned newly);
      logic [7:0] flags;
      int unsigned id, total, offset, payload;
      bit first_seg, is_last;
      newly = 0;
      if (len < HDR_BYTES || len >= COUNT_SAT) return ST_REJECT;
      if (hdr[63:56] != magic) return ST_REJECT;
      flags = hdr[55:48];
      id = 32'(hdr[47:32]);
      total = 32'(hdr[31:16]);
      offset = 32'(hdr[15:0]);
      payload = len - HDR_BYTES;
      first_seg = (flags & start_mask) != 0;
      is_last = (flags & end_mask) != 0;
      if (total == 0 || total > MAX_SDU_BYTES || offset > total || payload > total ||
          offset + payload > total) begin
         // A rejected start may have overwritten the old context's data.
         if (first_seg) drop_context();
         return ST_REJECT;
      end
      if (first_seg) begin
         ctx_on = 1;
         ctx_id = id[15:0];
         ctx_total = total;
         got_count = 0;
      end else if (!ctx_on || ctx_id != id[15:0] || ctx_total != total) begin
         return ST_REJECT;
      end
      if (offset > got_count) return ST_REJECT;
      if (offset < got_count) begin
         if (offset + payload > got_count) return ST_REJECT;
      end else begin
         got_count = offset + payload;
         newly = payload;
      end
      if (is_last) begin
         if (offset + payload != total || got_count != total) return ST_REJECT;
         sdu_len = total;
         rd_ptr = 0;
         drop_context();
         return ST_DONE;
      end
      return ST_TAKEN;
   endfunction

   // Notes one accepted request and queues the response it must produce.
   function void note_request(logic kind, logic [7:0] data, logic pdu_end);
      rsp_item_type r;
      int unsigned offset, base, pos, newly;
      r.status = ST_MID;
      r.consumed = '0;
      r.sdu_byte = '0;
      r.sdu_last = 0;
      requests++;
      if (kind) begin
         r.status = ST_EMPTY;
         if (pdu_len == 0 && sdu_len != 0 && rd_ptr < sdu_len && rd_ptr < MAX_SDU_BYTES) begin
            r.status = ST_READ;
            r.sdu_byte = store[rd_ptr];
            r.sdu_last = (rd_ptr + 1 == sdu_len);
            rd_ptr++;
            if (r.sdu_last) begin
               sdu_len = 0;
               rd_ptr = 0;
            end
         end
      end else begin
         // The first byte of a PDU throws away any undrained SDU.
         if (pdu_len == 0) begin
            sdu_len = 0;
            rd_ptr = 0;
            hdr = '0;
         end
         if (pdu_len < HDR_BYTES) begin
            hdr = {hdr[55:0], data};
         end else if (pdu_len < COUNT_SAT) begin
            offset = 32'(hdr[15:0]);
            base = got_count;
            if (hdr[63:56] == magic && (hdr[55:48] & start_mask) != 0) base = 0;
            pos = offset + pdu_len - HDR_BYTES;
            if (offset == base && pos < MAX_SDU_BYTES) store[pos] = data;
         end
         if (pdu_len < COUNT_SAT) pdu_len++;
         if (pdu_end) begin
            r.status = close_pdu(pdu_len, newly);
            r.consumed = newly[11:0];
            pdu_len = 0;
            hdr = '0;
         end
      end
      pending_q.push_back(r);
   endfunction

   // Compares one accepted response with the oldest expectation.
   function void check_response(logic [2:0] status, logic [11:0] consumed,
                                logic [7:0] sdu_byte, logic sdu_last);
      rsp_item_type r;
      if (pending_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected response: status %0d consumed %0d byte %h last %b",
                     status, consumed, sdu_byte, sdu_last);
         return;
      end
      r = pending_q.pop_front();
      if (status !== r.status || consumed !== r.consumed || sdu_byte !== r.sdu_byte ||
          sdu_last !== r.sdu_last) begin
         errors++;
         if (errors <= 10)
            $display({"response mismatch: expected status %0d consumed %0d byte %h last %b,",
                      " got status %0d consumed %0d byte %h last %b"},
                     r.status, r.consumed, r.sdu_byte, r.sdu_last,
                     status, consumed, sdu_byte, sdu_last);
      end
   endfunction
endclass

module segment_reassembler_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_kind = 0;
   logic [7:0]  req_data_byte = '0;
   logic        req_pdu_end = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_consumed_bytes;
   logic [7:0]  rsp_sdu_byte;
   logic        rsp_sdu_last;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   reassembly_scoreboard sb = new();
   bit          no_idle = 0;
   int unsigned quiet_cycles = 0;
   logic [15:0] sdu_id = 16'h1234;

   segment_reassembler u_top (.*);

   always #10 clock = ~clock;

   // Response side: random stalls, check on every accepted response.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_status, rsp_consumed_bytes, rsp_sdu_byte, rsp_sdu_last);
      rsp_ready <= no_idle || ($urandom_range(99) >= 9);
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Sends one request and waits until it is accepted.
   task automatic send_req(logic kind, logic [7:0] data, logic pdu_end);
      if (!no_idle && $urandom_range(99) < 9) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_data_byte <= data;
      req_pdu_end <= pdu_end;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, data, pdu_end);
   endtask

   // Sends a PDU with the given header and n random payload bytes.
   task automatic send_pdu(logic [7:0] mg, logic [7:0] flags, logic [15:0] id,
                           int unsigned total, int unsigned offset, int unsigned n);
      logic [63:0] h;
      h = {mg, flags, id, 16'(total), 16'(offset)};
      for (int i = 0; i < 8; i++) begin
         // A read before or inside the header; inside a PDU it must find nothing to read.
         if ($urandom_range(99) < 2)
            send_req(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
         send_req(1'b0, h[63 - 8 * i -: 8], (n == 0 && i == 7));
      end
      for (int unsigned i = 0; i < n; i++)
         send_req(1'b0, 8'($urandom_range(255)), i == n - 1);
   endtask

   // Random bytes of the given length, ended as a PDU.
   task automatic send_junk(int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         send_req(1'b0, 8'($urandom_range(255)), i == n - 1);
   endtask

   task automatic read_sdu(int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         send_req(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   function automatic logic [7:0] seg_flags(bit first, bit last);
      logic [7:0] f;
      f = 8'($urandom_range(255));
      f = f & ~(sb.start_mask | sb.end_mask);
      if (first) f = f | sb.start_mask;
      if (last) f = f | sb.end_mask;
      return f;
   endfunction

   // A well-formed SDU in random segments, with some duplicates, then drained fully or in part.
   task automatic good_sdu(int unsigned total, int unsigned max_seg);
      int unsigned off, len, prev_off, prev_len, lim;
      off = 0;
      prev_off = 0;
      prev_len = 0;
      sdu_id = 16'($urandom_range(65535));
      while (off < total) begin
         lim = (total - off < max_seg) ? total - off : max_seg;
         len = $urandom_range(1, lim);
         if (off > 0 && $urandom_range(99) < 12)
            send_pdu(sb.magic, seg_flags(1'b0, 1'b0), sdu_id, total, prev_off, prev_len);
         send_pdu(sb.magic, seg_flags(off == 0, off + len == total), sdu_id, total, off, len);
         prev_off = off;
         prev_len = len;
         off += len;
      end
      // Sometimes leave the SDU partly drained for the next PDU to discard.
      if ($urandom_range(99) < 10)
         read_sdu($urandom_range(0, total));
      else
         read_sdu(total + 1);
   endtask

   // One broken or foreign PDU, a broken sequence of three PDUs, or one to three stray reads.
   task automatic bad_pdu();
      int unsigned t;
      t = $urandom_range(16, 40);
      case ($urandom_range(7))
         0: send_junk($urandom_range(1, 12));
         1: send_pdu(sb.magic ^ 8'h01 << $urandom_range(7), seg_flags(1'b1, 1'b0), sdu_id,
                     t, 0, 4);
         2: send_pdu(sb.magic, seg_flags(1'b1, 1'b0), sdu_id, 0, 0, 0);
         3: send_pdu(sb.magic, seg_flags(1'($urandom_range(1)), 1'b0), sdu_id, 65535, 0, 3);
         4: send_pdu(sb.magic, seg_flags(1'b1, 1'b1), sdu_id, t, t + 1, 2);
         5: begin
            // A foreign id after a good start, then a gap.
            send_pdu(sb.magic, seg_flags(1'b1, 1'b0), sdu_id, t, 0, 5);
            send_pdu(sb.magic, seg_flags(1'b0, 1'b0), ~sdu_id, t, 5, 3);
            send_pdu(sb.magic, seg_flags(1'b0, 1'b1), sdu_id, t, 9, t - 9);
         end
         6: send_pdu(sb.magic, seg_flags(1'b0, 1'b1), sdu_id, t, 0, t);
         default: read_sdu($urandom_range(1, 3));
      endcase
   endtask

   // Lets the block go idle before a register write.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(logic [7:0] mg, logic [7:0] sm, logic [7:0] em);
      logic [7:0] v [3];
      csr_index_type idx;
      v = '{mg, sm, em};
      for (int i = 0; i < 3; i++) begin
         idx = csr_index_type'(i);
         csr_we <= 1;
         csr_index <= idx;
         csr_wdata <= v[i];
         @(posedge clock);
         sb.set_reg(idx, v[i]);
      end
      csr_we <= 0;
   endtask

   initial begin
      int unsigned goal;
      bit paused;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part on reset settings.
      read_sdu(1);
      send_pdu(sb.magic, seg_flags(1'b1, 1'b1), 16'h0000, 1, 0, 1);
      read_sdu(2);
      send_pdu(sb.magic, 8'hFF, 16'hFFFF, 3, 0, 3);
      read_sdu(4);
      send_junk(7);
      send_pdu(sb.magic, seg_flags(1'b1, 1'b0), 16'hA5A5, 2048, 2049, 0);
      // A largest-size context whose end check fails with data committed.
      send_pdu(sb.magic, seg_flags(1'b1, 1'b0), 16'h0F0F, 2048, 0, 40);
      send_pdu(sb.magic, seg_flags(1'b0, 1'b1), 16'h0F0F, 2048, 40, 30);
      read_sdu(2);
      send_pdu(sb.magic, seg_flags(1'b1, 1'b0), 16'h0002, 10, 0, 4);
      send_pdu(sb.magic, seg_flags(1'b0, 1'b0), 16'h0002, 10, 6, 2);
      send_pdu(sb.magic, seg_flags(1'b0, 1'b0), 16'h0002, 10, 2, 2);
      send_pdu(sb.magic, seg_flags(1'b0, 1'b0), 16'h0002, 10, 2, 4);
      send_pdu(sb.magic, seg_flags(1'b0, 1'b1), 16'h0002, 10, 4, 4);
      send_pdu(sb.magic, seg_flags(1'b1, 1'b0), 16'h0003, 0, 0, 1);

      // Random phases, each under its own register settings.
      paused = 0;
      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) begin
            drain();
            case (ph)
               1: write_regs(8'h00, 8'hFF, 8'h80);
               2: write_regs(8'hFF, 8'h80, 8'h01);
               default: write_regs(8'h5A, 8'h06, 8'h0C);
            endcase
         end
         no_idle = (ph == 2);
         goal = 240 + 370 * (ph + 1);
         while (sb.requests < goal) begin
            if ($urandom_range(99) < 80) good_sdu(($urandom_range(99) < 3) ?
                                                  $urandom_range(100, 300) :
                                                  $urandom_range(1, 40), 24);
            else bad_pdu();
            if (ph == 1 && !paused && sb.requests + 180 >= goal) begin
               paused = 1;
               req_valid <= 0;
               while (sb.pending() != 0) @(posedge clock);
            end
         end
      end
      no_idle = 0;
      drain();
      write_regs(8'd165, 8'd1, 8'd2);
      good_sdu(12, 5);

      req_valid <= 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
